FILE: sv/shell_command_line_tokenizer_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the command line tokenizer
// Property wrappers that expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef SHELL_COMMAND_LINE_TOKENIZER_UNIT_MACROS_SVH
`define SHELL_COMMAND_LINE_TOKENIZER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is high
`define SCTOK_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sctok assertion failed");
// next-cycle implication, disabled while reset is high
`define SCTOK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sctok assertion failed");
`else
`define SCTOK_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SCTOK_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: sv/sctok_pkg.sv
// ----------------------------------------------------------------------------
// sctok_pkg
// Shared types and constants of the command line tokenizer.
// ----------------------------------------------------------------------------
package sctok_pkg;

   localparam int OFF_W      = 14;
   localparam int MAX_LINE   = 8192;
   localparam logic [OFF_W-1:0] LINE_LIMIT = OFF_W'(MAX_LINE - 1);

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_E     = 8'h45;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CH_PIPE  = 8'h7C;

   typedef enum logic [3:0] {
      TK_EOL     = 4'd0,
      TK_TEXT    = 4'd1,
      TK_ANDAND  = 4'd2,
      TK_OROR    = 4'd3,
      TK_APPEND  = 4'd4,
      TK_AMP     = 4'd5,
      TK_PIPE    = 4'd6,
      TK_LT      = 4'd7,
      TK_GT      = 4'd8,
      TK_LPAREN  = 4'd9,
      TK_RPAREN  = 4'd10,
      TK_AT      = 4'd11,
      TK_TOOLONG = 4'd12
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type      kind;
      logic [OFF_W-1:0]  span_start;
      logic [OFF_W-1:0]  span_end;
      logic              last;
   } tok_res_type;

   // up to two tokens from one request
   typedef struct packed {
      logic [1:0]  count;
      tok_res_type res1;
      tok_res_type res0;
   } lex_out_type;

endpackage

FILE: sv/shell_command_line_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// shell_command_line_tokenizer_unit
// Splits a command line, one byte per request, into operator and text tokens.
//
//   channel | direction | tdata                           | tuser        | tlast
//   req_    | in        | [7:0] char_in                   | line_done    | -
//   rsp_    | out       | [13:0] span_start [27:14] end   | kind         | run_last
//
// One request is taken per cycle; its 0..2 tokens land in a four-entry result
// queue in the same edge and show on rsp_ from the next cycle, one per cycle.
// req_tready is high while the queue has room for two tokens, so bytes flow at
// one per cycle until two-token bytes or rsp_tready stalls fill it past two.
// Reset (synchronous) clears line state and empties the queue.
// ----------------------------------------------------------------------------
`include "shell_command_line_tokenizer_unit_macros.svh"

module shell_command_line_tokenizer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tuser,   // [0] line_done
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [13:0] span_start, [27:14] span_end, zero fill
   output logic [3:0]  rsp_tuser,   // [3:0] kind
   output logic        rsp_tlast    // run_last
);
   import sctok_pkg::*;

   lex_out_type       lex_out;
   tok_res_type       fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              req_accept;
   logic              rsp_accept;
   logic [1:0]        push_n;
   tok_res_type       head;
   logic              req_is_end;
   logic              rsp_is_final;

   assign req_tready = (fill_ff <= FILL_W'(FIFO_DEPTH - 2));
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_tvalid && rsp_tready;

   sctok_lex u_lex (
      .clock     (clock),
      .reset     (reset),
      .step      (req_accept),
      .char_in   (req_tdata),
      .line_done (req_tuser),
      .lex_out   (lex_out)
   );

   assign push_n    = req_accept ? lex_out.count : 2'd0;
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(rsp_accept);
   assign fill_in   = fill_ff + FILL_W'(push_n) - FILL_W'(rsp_accept);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // queue payload, no reset
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= lex_out.res0;
      end
      if (push_n == 2'd2) begin
         fifo_ff[wr_ptr_ff + PTR_W'(1)] <= lex_out.res1;
      end
   end

   assign head       = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = (fill_ff != '0);
   assign rsp_tdata  = {4'd0, head.span_end, head.span_start};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

   assign req_is_end   = req_tuser || (req_tdata == CH_NL) || (req_tdata == CH_NUL);
   assign rsp_is_final = (head.kind == TK_EOL) || (head.kind == TK_TOOLONG);

   `SCTOK_ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, fill_ff <= FILL_W'(FIFO_DEPTH))
   `SCTOK_ASSERT_NEXT(a_eol_queued, clock, reset, req_accept && req_is_end, rsp_tvalid)
   `SCTOK_ASSERT_IMPLY(a_eol_last, clock, reset, rsp_tvalid && rsp_is_final, rsp_tlast)

endmodule

FILE: sv/sctok_lex.sv
// ----------------------------------------------------------------------------
// sctok_lex
// Line state of the tokenizer and the per-byte step that yields 0..2 tokens.
// ----------------------------------------------------------------------------
module sctok_lex (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           char_in,
   input  logic                 line_done,
   output sctok_pkg::lex_out_type lex_out
);
   import sctok_pkg::*;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_TEXT = 2'd1,
      MODE_PEND = 2'd2
   } lex_mode_type;

   typedef struct packed {
      logic [OFF_W-1:0] line_offset;
      lex_mode_type     lex_mode;
      logic [1:0]       pending_op;
      logic [OFF_W-1:0] pending_offset;
      logic [OFF_W-1:0] text_start;
      logic [OFF_W-1:0] last_nonblank_end;
      logic             in_quotes;
      logic [2:0]       set_match_count;
      logic             parens_literal;
      logic             overflowed;
   } lex_state_type;

   typedef struct packed {
      lex_state_type  st;
      logic           emit;
      tok_kind_type   kind;
   } idle_ret_type;

   localparam lex_state_type STATE_RESET = '{
      line_offset: '0, lex_mode: MODE_IDLE, pending_op: '0, pending_offset: '0,
      text_start: '0, last_nonblank_end: '0, in_quotes: 1'b0,
      set_match_count: '0, parens_literal: 1'b0, overflowed: 1'b0};

   lex_state_type  state_ff, state_in;
   tok_res_type    res_a [2];
   logic [1:0]     cnt;
   logic [1:0]     k;
   logic [OFF_W-1:0] off;
   logic           is_end;
   idle_ret_type   idle_r;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic lex_state_type set_match(input lex_state_type s,
                                               input logic [7:0] c);
      lex_state_type r;
      logic [7:0]    u;
      logic [7:0]    want;
      r = s;
      u = ((c >= CH_LA) && (c <= CH_LZ)) ? (c - 8'h20) : c;
      case (s.set_match_count)
         3'd0:    want = CH_S;
         3'd1:    want = CH_E;
         default: want = CH_T;
      endcase
      if (s.set_match_count < 3'd3) begin
         r.set_match_count = (u == want) ? s.set_match_count + 3'd1 : 3'd4;
      end else if (s.set_match_count == 3'd3) begin
         r.parens_literal  = is_blank(c);
         r.set_match_count = 3'd4;
      end
      return r;
   endfunction

   function automatic idle_ret_type idle_byte(input lex_state_type s,
                                              input logic [7:0] c,
                                              input logic [OFF_W-1:0] o);
      idle_ret_type r;
      r.st   = s;
      r.emit = 1'b0;
      r.kind = TK_LT;
      if (is_blank(c) || (c == CH_CR)) begin
         r.emit = 1'b0;
      end else if ((c == CH_AMP) || (c == CH_PIPE) || (c == CH_GT)) begin
         r.st.lex_mode       = MODE_PEND;
         r.st.pending_op     = (c == CH_AMP) ? 2'd0 : (c == CH_PIPE) ? 2'd1 : 2'd2;
         r.st.pending_offset = o;
      end else if (c == CH_LT) begin
         r.emit = 1'b1;
         r.kind = TK_LT;
      end else if (c == CH_LPAR) begin
         r.emit = 1'b1;
         r.kind = TK_LPAREN;
      end else if (c == CH_RPAR) begin
         r.emit = 1'b1;
         r.kind = TK_RPAREN;
      end else if (c == CH_AT) begin
         r.emit = 1'b1;
         r.kind = TK_AT;
      end else begin
         r.st.lex_mode          = MODE_TEXT;
         r.st.text_start        = o;
         r.st.in_quotes         = (c == CH_QUOTE);
         r.st.parens_literal    = 1'b0;
         r.st.set_match_count   = 3'd0;
         r.st                   = set_match(r.st, c);
         r.st.last_nonblank_end = o + OFF_W'(1);
      end
      return r;
   endfunction

   function automatic logic is_meta(input lex_state_type s, input logic [7:0] c);
      logic m;
      m = (c == CH_AMP) || (c == CH_PIPE) || (c == CH_LT) || (c == CH_GT) ||
          (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_AT);
      if (s.in_quotes)
         m = 1'b0;
      else if (s.parens_literal && ((c == CH_LPAR) || (c == CH_RPAR)))
         m = 1'b0;
      return m;
   endfunction

   function automatic tok_res_type mk(input tok_kind_type kind,
                                      input logic [OFF_W-1:0] s,
                                      input logic [OFF_W-1:0] e);
      tok_res_type r;
      r.kind       = kind;
      r.span_start = s;
      r.span_end   = e;
      r.last       = 1'b0;
      return r;
   endfunction

   function automatic tok_kind_type pend_single(input logic [1:0] kk);
      tok_kind_type t;
      case (kk)
         2'd1:    t = TK_PIPE;
         2'd2:    t = TK_GT;
         default: t = TK_AMP;
      endcase
      return t;
   endfunction

   function automatic tok_kind_type pend_double(input logic [1:0] kk);
      tok_kind_type t;
      case (kk)
         2'd1:    t = TK_OROR;
         2'd2:    t = TK_APPEND;
         default: t = TK_ANDAND;
      endcase
      return t;
   endfunction

   function automatic logic [7:0] pend_char(input logic [1:0] kk);
      logic [7:0] ch;
      case (kk)
         2'd1:    ch = CH_PIPE;
         2'd2:    ch = CH_GT;
         default: ch = CH_AMP;
      endcase
      return ch;
   endfunction

   always_comb begin
      state_in = state_ff;
      res_a[0] = mk(TK_EOL, '0, '0);
      res_a[1] = mk(TK_EOL, '0, '0);
      cnt      = 2'd0;
      idle_r   = idle_byte(state_ff, char_in, state_ff.line_offset);
      k        = (state_ff.pending_op == 2'd3) ? 2'd0 : state_ff.pending_op;
      off      = state_ff.line_offset;
      is_end   = line_done || (char_in == CH_NL) || (char_in == CH_NUL);

      if (is_end) begin
         if (!state_ff.overflowed) begin
            if (state_ff.lex_mode == MODE_PEND) begin
               res_a[cnt[0]] = mk(pend_single(k), state_ff.pending_offset,
                                  state_ff.pending_offset + OFF_W'(1));
               cnt = cnt + 2'd1;
            end else if (state_ff.lex_mode == MODE_TEXT) begin
               res_a[cnt[0]] = mk(TK_TEXT, state_ff.text_start,
                                  state_ff.last_nonblank_end);
               cnt = cnt + 2'd1;
            end
         end
         res_a[cnt[0]] = mk(TK_EOL, off, off);
         cnt      = cnt + 2'd1;
         state_in = STATE_RESET;
      end else if (state_ff.overflowed) begin
         // drop bytes until the line ends
         state_in = state_ff;
      end else if (state_ff.line_offset >= LINE_LIMIT) begin
         res_a[cnt[0]] = mk(TK_TOOLONG, off, off);
         cnt                 = cnt + 2'd1;
         state_in.overflowed = 1'b1;
         state_in.lex_mode   = MODE_IDLE;
      end else begin
         state_in.line_offset = off + OFF_W'(1);
         case (state_ff.lex_mode)
            MODE_PEND: begin
               state_in.lex_mode = MODE_IDLE;
               if (char_in == pend_char(k)) begin
                  res_a[cnt[0]] = mk(pend_double(k), state_ff.pending_offset,
                                     off + OFF_W'(1));
                  cnt = cnt + 2'd1;
               end else begin
                  res_a[cnt[0]] = mk(pend_single(k), state_ff.pending_offset,
                                     state_ff.pending_offset + OFF_W'(1));
                  cnt    = cnt + 2'd1;
                  idle_r = idle_byte(state_in, char_in, off);
                  state_in = idle_r.st;
                  if (idle_r.emit) begin
                     res_a[cnt[0]] = mk(idle_r.kind, off, off + OFF_W'(1));
                     cnt = cnt + 2'd1;
                  end
               end
            end
            MODE_TEXT: begin
               if (char_in == CH_QUOTE) begin
                  state_in.in_quotes = ~state_ff.in_quotes;
                  state_in = set_match(state_in, char_in);
                  state_in.last_nonblank_end = off + OFF_W'(1);
               end else if (is_meta(state_ff, char_in)) begin
                  res_a[cnt[0]] = mk(TK_TEXT, state_ff.text_start,
                                     state_ff.last_nonblank_end);
                  cnt = cnt + 2'd1;
                  state_in.lex_mode = MODE_IDLE;
                  idle_r = idle_byte(state_in, char_in, off);
                  state_in = idle_r.st;
                  if (idle_r.emit) begin
                     res_a[cnt[0]] = mk(idle_r.kind, off, off + OFF_W'(1));
                     cnt = cnt + 2'd1;
                  end
               end else begin
                  state_in = set_match(state_in, char_in);
                  if (!is_blank(char_in))
                     state_in.last_nonblank_end = off + OFF_W'(1);
               end
            end
            default: begin
               idle_r = idle_byte(state_in, char_in, off);
               state_in = idle_r.st;
               if (idle_r.emit) begin
                  res_a[cnt[0]] = mk(idle_r.kind, off, off + OFF_W'(1));
                  cnt = cnt + 2'd1;
               end
            end
         endcase
      end

      // mark the final token of this request
      if (cnt == 2'd1)
         res_a[0].last = 1'b1;
      else if (cnt == 2'd2)
         res_a[1].last = 1'b1;
   end

   assign lex_out.count = cnt;
   assign lex_out.res0  = res_a[0];
   assign lex_out.res1  = res_a[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
      end else if (step) begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: tb/shell_command_line_tokenizer_unit_tb.sv
// ----------------------------------------------------------------------------
// shell_command_line_tokenizer_unit_tb
// Feeds command lines into the tokenizer one byte per request and checks each
// token against a behavioural model of the lexer in this bench. A short table
// of hand-picked lines runs first, its typed rows checked against their own row. Random
// lines follow, built from words, blanks, quotes, SET forms, operators and stray bytes.
// ----------------------------------------------------------------------------
module shell_command_line_tokenizer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sctok_pkg::*;

   localparam int         RANDOM_REQS = 1400;
   localparam int         IDLE_LIMIT  = 2000;
   localparam int         TAIL_CYCLES = 20;
   localparam int         N_DIR       = 28;
   localparam logic [2:0] SET_BLANK   = 3'd3;
   localparam logic [2:0] SET_DONE    = 3'd4;
   localparam logic [7:0] CASE_BIT    = 8'h20;

   typedef enum logic [1:0] {LX_IDLE, LX_TEXT, LX_PEND} lex_mode_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       done;
   } char_req_type;

   typedef struct packed {
      logic [7:0]       ch;
      logic             done;
      logic             typed;     // expectation written out below
      logic             one_tok;   // typed row gives exactly one token
      tok_kind_type     kind;
      logic [OFF_W-1:0] s_off;
      logic [OFF_W-1:0] e_off;
   } dir_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] char_in
   logic        req_tuser  = 1'b0; // [0] line_done
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [13:0] span_start, [27:14] span_end
   logic [3:0]  rsp_tuser;         // [3:0] kind
   logic        rsp_tlast;         // run_last

   // lexer state of the bench
   logic [OFF_W-1:0] cur_off, pend_off, word_start, word_end;
   lex_mode_type     lex_mode;
   tok_kind_type     pend_kind;
   logic             quoted, parens_lit, overflowed;
   logic [2:0]       set_cnt;

   tok_res_type  byte_toks[$];
   tok_res_type  tokens_due[$];
   char_req_type line_q[$];

   int          mismatches = 0;
   int          n_req = 0, n_random = 0, n_lines = 0, n_long = 0, n_tok = 0;
   int          burst_left = 0;
   logic [15:0] kinds_seen = '0;

   dir_row_type dir_rows [N_DIR] = '{
      '{8'h00,    1'b1, 1'b1, 1'b1, TK_EOL,    14'd0, 14'd0},
      '{CH_LT,    1'b0, 1'b1, 1'b1, TK_LT,     14'd0, 14'd1},
      '{CH_AMP,   1'b0, 1'b1, 1'b0, TK_EOL,    14'd0, 14'd0},
      '{CH_AMP,   1'b0, 1'b1, 1'b1, TK_ANDAND, 14'd1, 14'd3},
      '{CH_PIPE,  1'b0, 1'b1, 1'b0, TK_EOL,    14'd0, 14'd0},
      '{CH_PIPE,  1'b0, 1'b1, 1'b1, TK_OROR,   14'd3, 14'd5},
      '{CH_GT,    1'b0, 1'b1, 1'b0, TK_EOL,    14'd0, 14'd0},
      '{CH_GT,    1'b0, 1'b1, 1'b1, TK_APPEND, 14'd5, 14'd7},
      '{CH_GT,    1'b0, 1'b1, 1'b0, TK_EOL,    14'd0, 14'd0},
      '{8'hFF,    1'b0, 1'b0, 1'b0, TK_EOL,    14'd0, 14'd0},
      '{CH_AT,    1'b0, 1'b0, 1'b0, TK_EOL,    14'd0, 14'd0},
      '{CH_RPAR,  1'b0, 1'b0, 1'b0, TK_EOL,    14'd0, 14'd0},
      '{CH_PIPE,  1'b0, 1'b0, 1'b0, TK_EOL,    14'd0, 14'd0},
      '{CH_NUL,   1'b0, 1'b0, 1'b0, TK_EOL,    14'd0, 14'd0},
      // lower/upper case SET then tab: parens stay inside the text
      '{"s",      1'b0, 1'b0, 1'b0, TK_EOL,    14'd0, 14'd0},
      '{"E",      1'b0, 1'b0, 1'b0, TK_EOL,    14'd0, 14'd0},
      '{"t",      1'b0, 1'b0, 1'b0, TK_EOL,    14'd0, 14'd0},
      '{CH_TAB,   1'b0, 1'b0, 1'b0, TK_EOL,    14'd0, 14'd0},
      '{CH_LPAR,  1'b0, 1'b0, 1'b0, TK_EOL,    14'd0, 14'd0},
      '{CH_QUOTE, 1'b0, 1'b0, 1'b0, TK_EOL,    14'd0, 14'd0},
      '{CH_AMP,   1'b0, 1'b0, 1'b0, TK_EOL,    14'd0, 14'd0},
      '{CH_QUOTE, 1'b0, 1'b0, 1'b0, TK_EOL,    14'd0, 14'd0},
      '{CH_CR,    1'b0, 1'b0, 1'b0, TK_EOL,    14'd0, 14'd0},
      '{CH_SPACE, 1'b0, 1'b0, 1'b0, TK_EOL,    14'd0, 14'd0},
      '{CH_NL,    1'b0, 1'b0, 1'b0, TK_EOL,    14'd0, 14'd0},
      '{CH_LPAR,  1'b0, 1'b1, 1'b1, TK_LPAREN, 14'd0, 14'd1},
      '{CH_AMP,   1'b0, 1'b0, 1'b0, TK_EOL,    14'd0, 14'd0},
      // end item: its byte is ignored
      '{"a",      1'b1, 1'b0, 1'b0, TK_EOL,    14'd0, 14'd0}
   };

   shell_command_line_tokenizer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- lexer model

   function automatic void clear_line();
      cur_off    = '0;
      lex_mode   = LX_IDLE;
      pend_kind  = TK_AMP;
      pend_off   = '0;
      word_start = '0;
      word_end   = '0;
      quoted     = 1'b0;
      set_cnt    = '0;
      parens_lit = 1'b0;
      overflowed = 1'b0;
   endfunction

   function automatic void emit_token(tok_kind_type kind, logic [OFF_W-1:0] s_off,
                                      logic [OFF_W-1:0] e_off);
      tok_res_type t;
      if (byte_toks.size() > 0)
         byte_toks[byte_toks.size()-1].last = 1'b0;
      t.kind       = kind;
      t.span_start = s_off;
      t.span_end   = e_off;
      t.last       = 1'b1;
      byte_toks.push_back(t);
   endfunction

   // track the SET prefix; a blank right after it makes parens literal
   function automatic void note_set_word(logic [7:0] ch);
      logic [7:0] up, want;
      up = (ch >= CH_LA && ch <= CH_LZ) ? (ch ^ CASE_BIT) : ch;
      if (set_cnt < SET_BLANK) begin
         case (set_cnt)
            3'd0:    want = CH_S;
            3'd1:    want = CH_E;
            default: want = CH_T;
         endcase
         set_cnt = (up == want) ? set_cnt + 3'd1 : SET_DONE;
      end else if (set_cnt == SET_BLANK) begin
         parens_lit = (ch == CH_SPACE || ch == CH_TAB);
         set_cnt    = SET_DONE;
      end
   endfunction

   // byte seen between tokens
   function automatic void open_token(logic [7:0] ch, logic [OFF_W-1:0] off);
      case (ch)
         CH_SPACE, CH_TAB, CH_CR: ;
         CH_AMP, CH_PIPE, CH_GT: begin
            lex_mode  = LX_PEND;
            pend_kind = (ch == CH_AMP) ? TK_AMP : (ch == CH_PIPE) ? TK_PIPE : TK_GT;
            pend_off  = off;
         end
         CH_LT:   emit_token(TK_LT, off, off + 1'b1);
         CH_LPAR: emit_token(TK_LPAREN, off, off + 1'b1);
         CH_RPAR: emit_token(TK_RPAREN, off, off + 1'b1);
         CH_AT:   emit_token(TK_AT, off, off + 1'b1);
         default: begin
            lex_mode   = LX_TEXT;
            word_start = off;
            quoted     = (ch == CH_QUOTE);
            parens_lit = 1'b0;
            set_cnt    = '0;
            note_set_word(ch);
            word_end   = off + 1'b1;
         end
      endcase
   endfunction

   function automatic void tokenize_byte(logic [7:0] ch, logic done);
      logic [OFF_W-1:0] off;
      logic [7:0]       pair;
      tok_kind_type     dbl;
      byte_toks.delete();
      if (done || ch == CH_NL || ch == CH_NUL) begin
         if (!overflowed) begin
            if (lex_mode == LX_PEND)
               emit_token(pend_kind, pend_off, pend_off + 1'b1);
            else if (lex_mode == LX_TEXT)
               emit_token(TK_TEXT, word_start, word_end);
         end
         emit_token(TK_EOL, cur_off, cur_off);
         n_lines++;
         clear_line();
      end else if (!overflowed) begin
         if (cur_off >= LINE_LIMIT) begin
            // drop whatever was open and ignore the rest of the line
            emit_token(TK_TOOLONG, cur_off, cur_off);
            n_long++;
            overflowed = 1'b1;
            lex_mode   = LX_IDLE;
         end else begin
            off     = cur_off;
            cur_off = cur_off + 1'b1;
            if (lex_mode == LX_PEND) begin
               case (pend_kind)
                  TK_AMP:  begin pair = CH_AMP;  dbl = TK_ANDAND; end
                  TK_PIPE: begin pair = CH_PIPE; dbl = TK_OROR;   end
                  default: begin pair = CH_GT;   dbl = TK_APPEND; end
               endcase
               lex_mode = LX_IDLE;
               if (ch == pair) begin
                  emit_token(dbl, pend_off, off + 1'b1);
               end else begin
                  emit_token(pend_kind, pend_off, pend_off + 1'b1);
                  open_token(ch, off);
               end
            end else if (lex_mode == LX_TEXT) begin
               if (ch == CH_QUOTE) begin
                  quoted = !quoted;
                  note_set_word(ch);
                  word_end = off + 1'b1;
               end else if (!quoted && (ch == CH_AMP || ch == CH_PIPE || ch == CH_LT ||
                                        ch == CH_GT || ch == CH_AT ||
                                        (!parens_lit && (ch == CH_LPAR || ch == CH_RPAR))))
               begin
                  emit_token(TK_TEXT, word_start, word_end);
                  lex_mode = LX_IDLE;
                  open_token(ch, off);
               end else begin
                  note_set_word(ch);
                  // CR stays in the span, only space and tab are trimmed
                  if (ch != CH_SPACE && ch != CH_TAB)
                     word_end = off + 1'b1;
               end
            end else begin
               open_token(ch, off);
            end
         end
      end
   endfunction

   // ------------------------------------------------------------ line builder

   function automatic logic [7:0] word_char();
      case ($urandom_range(0, 3))
         0:       return CH_LA + 8'($urandom_range(0, 25));
         1:       return "A" + 8'($urandom_range(0, 25));
         2:       return "0" + 8'($urandom_range(0, 9));
         default: return "-" + 8'($urandom_range(0, 2));
      endcase
   endfunction

   function automatic logic [7:0] any_meta();
      case ($urandom_range(0, 6))
         0:       return CH_AMP;
         1:       return CH_PIPE;
         2:       return CH_LT;
         3:       return CH_GT;
         4:       return CH_LPAR;
         5:       return CH_RPAR;
         default: return CH_AT;
      endcase
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 3))
         0, 1:    return CH_SPACE;
         2:       return CH_TAB;
         default: return CH_CR;
      endcase
   endfunction

   // any byte that does not end the line
   function automatic logic [7:0] odd_byte();
      logic [7:0] b;
      b = 8'($urandom_range(1, 255));
      return (b == CH_NL) ? CH_NL + 8'd1 : b;
   endfunction

   function automatic void append_char(logic [7:0] ch);
      char_req_type r;
      r.ch   = ch;
      r.done = 1'b0;
      line_q.push_back(r);
   endfunction

   function automatic void add_piece();
      int         n;
      logic [7:0] ch;
      case ($urandom_range(0, 11))
         0, 1, 2: begin
            n = $urandom_range(1, 6);
            repeat (n) append_char(word_char());
         end
         3: begin
            // quoted run with metacharacters, left open now and then
            append_char(CH_QUOTE);
            n = $urandom_range(0, 5);
            repeat (n) append_char($urandom_range(0, 1) ? word_char() : any_meta());
            if ($urandom_range(0, 3) != 0)
               append_char(CH_QUOTE);
         end
         4, 5: begin
            append_char($urandom_range(0, 1) ? CH_S : (CH_S | CASE_BIT));
            append_char($urandom_range(0, 1) ? CH_E : (CH_E | CASE_BIT));
            append_char($urandom_range(0, 1) ? CH_T : (CH_T | CASE_BIT));
            append_char(($urandom_range(0, 3) != 0) ? pick_blank() : word_char());
            n = $urandom_range(0, 6);
            repeat (n)
               case ($urandom_range(0, 3))
                  0:       append_char(CH_LPAR);
                  1:       append_char(CH_RPAR);
                  2:       append_char(word_char());
                  default: append_char(pick_blank());
               endcase
         end
         6, 7: begin
            ch = any_meta();
            append_char(ch);
            if ($urandom_range(0, 1))
               append_char(ch);
         end
         8: begin
            append_char(any_meta());
            append_char(any_meta());
         end
         9: append_char(odd_byte());
         default: begin
            n = $urandom_range(1, 3);
            repeat (n) append_char(pick_blank());
         end
      endcase
      if ($urandom_range(0, 2) != 0)
         append_char(pick_blank());
   endfunction

   function automatic void end_line();
      char_req_type r;
      case ($urandom_range(0, 3))
         0, 1:    begin r.ch = CH_NL;  r.done = 1'b0; end
         2:       begin r.ch = CH_NUL; r.done = 1'b0; end
         default: begin r.ch = 8'($urandom_range(0, 255)); r.done = 1'b1; end
      endcase
      line_q.push_back(r);
   endfunction

   // ----------------------------------------------------------------- driving

   task automatic send_char(input logic [7:0] ch, input logic done, input bit keep_pred);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                                 : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= done;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_req++;
      tokenize_byte(ch, done);
      if (keep_pred)
         foreach (byte_toks[i]) tokens_due.push_back(byte_toks[i]);
   endtask

   // hold the sender until every token owed has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (tokens_due.size() != 0);
   endtask

   task automatic send_line();
      foreach (line_q[i]) send_char(line_q[i].ch, line_q[i].done, 1'b1);
   endtask

   initial begin : stimulus
      tok_res_type t;
      clear_line();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIR; i++) begin
         send_char(dir_rows[i].ch, dir_rows[i].done, !dir_rows[i].typed);
         if (dir_rows[i].typed && dir_rows[i].one_tok) begin
            t.kind       = dir_rows[i].kind;
            t.span_start = dir_rows[i].s_off;
            t.span_end   = dir_rows[i].e_off;
            t.last       = 1'b1;
            tokens_due.push_back(t);
         end
      end
      drain();

      while (n_random < RANDOM_REQS) begin
         line_q.delete();
         case ($urandom_range(0, 9))
            0: repeat ($urandom_range(1, 24)) begin
               // raw noise, terminators included
               t.kind = TK_EOL;
               line_q.push_back('{8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0)});
            end
            1: repeat ($urandom_range(0, 3)) append_char(pick_blank());
            default: repeat ($urandom_range(1, 8)) add_piece();
         endcase
         end_line();
         send_line();
         n_random += line_q.size();
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tokens_due.size() != 0) begin
         $display("%0d expected tokens never arrived", tokens_due.size());
         mismatches += tokens_due.size();
      end
      $display("%0d requests in %0d lines (%0d cut off as too long), %0d tokens checked",
               n_req, n_lines, n_long, n_tok);
      $display("%0d of 13 token kinds seen, %0d mismatches", $countones(kinds_seen),
               mismatches);
      if (mismatches == 0)
         $display("shell_command_line_tokenizer_unit_tb: PASS");
      else
         $display("shell_command_line_tokenizer_unit_tb: FAIL");
      $finish;
   end

   // receiver stalls on a 16-bit ready mask, replaced every four turns through it
   initial begin : rsp_stall
      logic [15:0] mask;
      logic [5:0]  pos;
      mask = '1;
      pos  = '0;
      forever begin
         @(posedge clock);
         if (pos == 6'd0)
            case ($urandom_range(0, 3))
               0:       mask = '1;
               1:       mask = 16'($urandom) | 16'h0001;
               2:       mask = (16'($urandom) & 16'($urandom)) | 16'h0001;
               default: mask = ~(16'h0001 << $urandom_range(0, 15));
            endcase
         rsp_tready <= mask[pos[3:0]];
         pos = pos + 6'd1;
      end
   end

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin : token_check
      tok_res_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind       = tok_kind_type'(rsp_tuser);
         got.span_start = rsp_tdata[OFF_W-1:0];
         got.span_end   = rsp_tdata[2*OFF_W-1:OFF_W];
         got.last       = rsp_tlast;
         n_tok++;
         kinds_seen[rsp_tuser] = 1'b1;
         if (tokens_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected token: kind %0d span %0d..%0d last %0b",
                        rsp_tuser, got.span_start, got.span_end, got.last);
         end else begin
            want = tokens_due.pop_front();
            if (got.kind !== want.kind || got.span_start !== want.span_start ||
                got.span_end !== want.span_end || got.last !== want.last ||
                rsp_tdata[31:2*OFF_W] !== '0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("token %0d: expected kind %0d span %0d..%0d last %0b, got kind %0d %s",
                           n_tok, want.kind, want.span_start, want.span_end, want.last,
                           rsp_tuser, $sformatf("span %0d..%0d last %0b fill %h",
                           got.span_start, got.span_end, got.last, rsp_tdata[31:2*OFF_W]));
            end
         end
      end
   end

   // end the run if neither side moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("no request or token moved for %0d cycles", IDLE_LIMIT);
      $display("shell_command_line_tokenizer_unit_tb: FAIL");
      $finish;
   end

endmodule

FILE: shell_command_line_tokenizer_unit.f
+incdir+sv
sv/sctok_pkg.sv
sv/sctok_lex.sv
sv/shell_command_line_tokenizer_unit.sv
tb/shell_command_line_tokenizer_unit_tb.sv
